// ===== src/tile_residency_lru_controller_top_assert.svh =====
// Assertion macros for the tile residency controller top level.
// Needs clk and rst_n in the including scope.
`ifndef TILE_RESIDENCY_LRU_CONTROLLER_TOP_ASSERT_SVH
`define TILE_RESIDENCY_LRU_CONTROLLER_TOP_ASSERT_SVH

// implication checked on every clock edge outside reset
`define TLRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlrc assertion failed");

// implication with the consequent checked at the next clock edge
`define TLRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlrc assertion failed");

`endif

// ===== src/tlrc_pkg.sv =====
// Shared types and constants for the tile residency LRU controller.
// No dependencies.
package tlrc_pkg;

  localparam int TLRC_GRID_TILES     = 16;
  localparam int TLRC_RESIDENT_SLOTS = 4;
  localparam int TLRC_TS_W           = 9;
  localparam int TLRC_COORD_W        = 16;
  localparam int TLRC_OUT_W          = 48;
  localparam logic [TLRC_TS_W-1:0] TLRC_TS_RESET = 9'd16;
  localparam logic [TLRC_TS_W-1:0] TLRC_TS_MAX   = 9'd256;

  localparam logic [1:0] LOAD_HIT  = 2'd0;
  localparam logic [1:0] LOAD_ZERO = 2'd1;
  localparam logic [1:0] LOAD_READ = 2'd2;

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_LOOK  = 9'b000001000,
    S_EVRD  = 9'b000010000,
    S_EVCHK = 9'b000100000,
    S_LDRD  = 9'b001000000,
    S_LDCHK = 9'b010000000,
    S_OUT   = 9'b100000000
  } tlrc_state_t;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic div_step;
    logic look;
    logic ev_rd;
    logic ev_chk;
    logic ld_rd;
    logic ld_chk;
    logic out_load;
  } tlrc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic neg;
    logic div_last;
    logic oog;
    logic hit;
    logic full;
    logic out_free;
  } tlrc_status_t;

endpackage

// ===== src/tlrc_ram.sv =====
// Generic single write port RAM with registered read.
// No dependencies.
module tlrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== src/tlrc_ctrl.sv =====
// Sequencer for the tile residency controller.
// Depends on tlrc_pkg.
module tlrc_ctrl import tlrc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  tlrc_status_t status,
  output tlrc_cmd_t    cmd
);

  tlrc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        if (status.neg) begin
          state_nxt = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
          if (status.div_last) state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        if (status.oog || status.hit) state_nxt = S_OUT;
        else if (status.full)         state_nxt = S_EVRD;
        else                          state_nxt = S_LDRD;
      end
      S_EVRD: begin
        cmd.ev_rd = 1'b1;
        state_nxt = S_EVCHK;
      end
      S_EVCHK: begin
        cmd.ev_chk = 1'b1;
        state_nxt  = S_LDRD;
      end
      S_LDRD: begin
        cmd.ld_rd = 1'b1;
        state_nxt = S_LDCHK;
      end
      S_LDCHK: begin
        cmd.ld_chk = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

endmodule

// ===== src/tlrc_dp.sv =====
// Datapath: divider, slot table with LRU ranks, backing index RAM, result register.
// Depends on tlrc_pkg and tlrc_ram.
module tlrc_dp import tlrc_pkg::*; #(
  parameter int GRID_TILES     = TLRC_GRID_TILES,
  parameter int RESIDENT_SLOTS = TLRC_RESIDENT_SLOTS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  input  logic [TLRC_TS_W-1:0]    cfg_tile_size,
  input  logic [2*TLRC_COORD_W-1:0] in_tdata,
  input  logic                    out_tready,
  output logic                    out_tvalid,
  output logic [TLRC_OUT_W-1:0]   out_tdata,
  input  tlrc_cmd_t               cmd,
  output tlrc_status_t            status
);

  localparam int NT = GRID_TILES * GRID_TILES;
  localparam int TB = (GRID_TILES > 1) ? $clog2(GRID_TILES) : 1;
  localparam int TW = (NT > 1) ? $clog2(NT) : 1;
  localparam int RW = $clog2(NT + 1);
  localparam int SW = (RESIDENT_SLOTS > 1) ? $clog2(RESIDENT_SLOTS) : 1;
  localparam int QW = TLRC_COORD_W - 1;
  localparam logic [SW-1:0] LAST_RANK = SW'(RESIDENT_SLOTS - 1);
  localparam logic [QW-1:0] GRID_Q    = QW'(GRID_TILES);
  localparam logic [TW-1:0] GRID_T    = TW'(GRID_TILES);

  logic [TLRC_TS_W-1:0] ts_r, ts_eff;
  logic [QW-1:0]        xq_r, yq_r;
  logic [TLRC_TS_W-1:0] xr_r, yr_r;
  logic                 neg_r;
  logic [3:0]           cnt_r;
  logic [TB-1:0]        own_x_r [RESIDENT_SLOTS];
  logic [TB-1:0]        own_y_r [RESIDENT_SLOTS];
  logic [RESIDENT_SLOTS-1:0] used_r, used_nxt;
  logic [SW-1:0]        rank_r [RESIDENT_SLOTS];
  logic [SW-1:0]        rank_nxt [RESIDENT_SLOTS];
  logic [RW-1:0]        next_r;
  logic [TW-1:0]        clr_cnt_r;
  logic [SW-1:0]        vslot_r;

  logic                 res_ok_r, res_ev_r, res_enew_r;
  logic [1:0]           res_slot_r, res_la_r;
  logic [15:0]          res_pidx_r;
  logic [7:0]           res_lrec_r, res_erec_r;
  logic [3:0]           res_ex_r, res_ey_r;
  logic                 out_tvalid_r;
  logic [TLRC_OUT_W-1:0] out_tdata_r;

  always_comb begin
    if (ts_r == '0)               ts_eff = 9'd1;
    else if (ts_r > TLRC_TS_MAX)  ts_eff = TLRC_TS_MAX;
    else                          ts_eff = ts_r;
  end

  // restoring divider step, both coordinates in parallel
  logic [TLRC_TS_W:0] xs, ys;
  logic               xge, yge;
  assign xs  = {xr_r, xq_r[QW-1]};
  assign ys  = {yr_r, yq_r[QW-1]};
  assign xge = xs >= {1'b0, ts_eff};
  assign yge = ys >= {1'b0, ts_eff};

  logic          oog;
  logic [TB-1:0] tx, ty;
  logic [TW-1:0] t_idx, e_idx;
  assign oog   = (xq_r >= GRID_Q) || (yq_r >= GRID_Q);
  assign tx    = xq_r[TB-1:0];
  assign ty    = yq_r[TB-1:0];
  assign t_idx = TW'(TW'(ty) * GRID_T + TW'(tx));
  assign e_idx = TW'(TW'(own_y_r[vslot_r]) * GRID_T + TW'(own_x_r[vslot_r]));

  logic [17:0] prod;
  assign prod = 18'(yr_r) * 18'(ts_eff) + 18'(xr_r);

  // slot lookup
  logic          hit, full, vfound, ffound;
  logic [SW-1:0] hslot, vslot, fslot;
  always_comb begin
    hit    = 1'b0;
    hslot  = '0;
    vfound = 1'b0;
    vslot  = '0;
    ffound = 1'b0;
    fslot  = '0;
    for (int i = 0; i < RESIDENT_SLOTS; i++) begin
      if (!hit && used_r[i] && own_x_r[i] == tx && own_y_r[i] == ty) begin
        hit   = 1'b1;
        hslot = SW'(i);
      end
      if (!vfound && used_r[i] && rank_r[i] == LAST_RANK) begin
        vfound = 1'b1;
        vslot  = SW'(i);
      end
      if (!ffound && !used_r[i]) begin
        ffound = 1'b1;
        fslot  = SW'(i);
      end
    end
  end
  assign full = &used_r;

  // LRU rank update
  logic          tch_en, tch_fresh;
  logic [SW-1:0] tch_s;
  always_comb begin
    tch_en    = 1'b0;
    tch_fresh = 1'b0;
    tch_s     = hslot;
    used_nxt  = used_r;
    for (int i = 0; i < RESIDENT_SLOTS; i++) rank_nxt[i] = rank_r[i];
    if (cmd.look && !oog && hit) begin
      tch_en = 1'b1;
    end
    if (cmd.ev_chk) begin
      used_nxt[vslot_r] = 1'b0;
      rank_nxt[vslot_r] = '0;
    end
    if (cmd.ld_chk) begin
      tch_en          = 1'b1;
      tch_fresh       = 1'b1;
      tch_s           = fslot;
      used_nxt[fslot] = 1'b1;
    end
    if (tch_en) begin
      for (int i = 0; i < RESIDENT_SLOTS; i++) begin
        if (SW'(i) == tch_s) begin
          rank_nxt[i] = '0;
        end else if (used_r[i] && (tch_fresh || rank_r[i] < rank_r[tch_s])) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
    end
  end

  // backing index RAM: record number + 1, zero for none
  logic          ram_we;
  logic [TW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;
  logic          ev_zero;
  assign ev_zero   = (ram_rdata == '0);
  assign ram_raddr = cmd.ev_rd ? e_idx : t_idx;
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_r;
    ram_wdata = '0;
    if (cmd.clr_wr) begin
      ram_we = 1'b1;
    end else if (cmd.ev_chk && ev_zero) begin
      ram_we    = 1'b1;
      ram_waddr = e_idx;
      ram_wdata = next_r + 1'b1;
    end
  end

  tlrc_ram #(.WIDTH(RW), .DEPTH(NT)) u_bk_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r         <= TLRC_TS_RESET;
      used_r       <= '0;
      next_r       <= '0;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < RESIDENT_SLOTS; i++) rank_r[i] <= '0;
    end else begin
      if (cfg_valid) ts_r <= cfg_tile_size;
      if (cmd.clr_wr) clr_cnt_r <= clr_cnt_r + 1'b1;
      used_r <= used_nxt;
      for (int i = 0; i < RESIDENT_SLOTS; i++) rank_r[i] <= rank_nxt[i];
      if (cmd.ev_chk && ev_zero) next_r <= next_r + 1'b1;
      if (cmd.out_load)        out_tvalid_r <= 1'b1;
      else if (out_tready)     out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xq_r       <= in_tdata[QW-1:0];
      yq_r       <= in_tdata[TLRC_COORD_W+QW-1:TLRC_COORD_W];
      neg_r      <= in_tdata[TLRC_COORD_W-1] | in_tdata[2*TLRC_COORD_W-1];
      xr_r       <= '0;
      yr_r       <= '0;
      cnt_r      <= 4'(QW);
      res_ok_r   <= 1'b0;
      res_slot_r <= '0;
      res_pidx_r <= '0;
      res_la_r   <= LOAD_HIT;
      res_lrec_r <= '0;
      res_ev_r   <= 1'b0;
      res_ex_r   <= '0;
      res_ey_r   <= '0;
      res_erec_r <= '0;
      res_enew_r <= 1'b0;
    end
    if (cmd.div_step) begin
      xr_r  <= xge ? TLRC_TS_W'(xs - {1'b0, ts_eff}) : xs[TLRC_TS_W-1:0];
      yr_r  <= yge ? TLRC_TS_W'(ys - {1'b0, ts_eff}) : ys[TLRC_TS_W-1:0];
      xq_r  <= {xq_r[QW-2:0], xge};
      yq_r  <= {yq_r[QW-2:0], yge};
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.look && !oog) begin
      res_ok_r   <= 1'b1;
      res_pidx_r <= prod[15:0];
      res_slot_r <= 2'(hslot);
      vslot_r    <= vslot;
    end
    if (cmd.ev_chk) begin
      res_ev_r   <= 1'b1;
      res_ex_r   <= 4'(own_x_r[vslot_r]);
      res_ey_r   <= 4'(own_y_r[vslot_r]);
      res_enew_r <= ev_zero;
      res_erec_r <= ev_zero ? 8'(next_r) : 8'(ram_rdata - 1'b1);
    end
    if (cmd.ld_chk) begin
      res_slot_r      <= 2'(fslot);
      own_x_r[fslot]  <= tx;
      own_y_r[fslot]  <= ty;
      res_la_r        <= ev_zero ? LOAD_ZERO : LOAD_READ;
      res_lrec_r      <= ev_zero ? 8'd0 : 8'(ram_rdata - 1'b1);
    end
    if (cmd.out_load) begin
      out_tdata_r <= {1'b0, res_enew_r, res_erec_r, res_ey_r, res_ex_r, res_ev_r,
                      res_lrec_r, res_la_r, res_pidx_r, res_slot_r, res_ok_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign status.clr_last = (clr_cnt_r == TW'(NT - 1));
  assign status.neg      = neg_r;
  assign status.div_last = (cnt_r == 4'd1);
  assign status.oog      = oog;
  assign status.hit      = hit;
  assign status.full     = full;
  assign status.out_free = !out_tvalid_r || out_tready;

endmodule

// ===== src/tile_residency_lru_controller_top.sv =====
// Top level of the tile residency LRU controller: sequencer plus datapath.
// Depends on tlrc_pkg, tlrc_ctrl, tlrc_dp and the assertion macro header.
//
//  channel  direction  handshake               payload
//  in_      slave      in_tvalid/in_tready     coord_x, coord_y
//  out_     master     out_tvalid/out_tready   result fields
//  cfg_     slave      cfg_valid/cfg_ready     tile_size
//
// Per request: accept, 15 divider steps, lookup, then on a miss a RAM read and
// check (after another on an eviction), and an output load once the output
// register is free; negative, out-of-grid and hit requests skip to that load.
// After reset a clearing pass over every backing RAM entry holds in_tready low.
// A result waits in the output register while the next request is taken.
module tile_residency_lru_controller_top import tlrc_pkg::*; #(
  parameter int GRID_TILES     = TLRC_GRID_TILES,
  parameter int RESIDENT_SLOTS = TLRC_RESIDENT_SLOTS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [TLRC_TS_W-1:0]      cfg_tile_size,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [2*TLRC_COORD_W-1:0] in_tdata,   // coord_x, coord_y
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // ok, slot, point_index, load_action, load_record, evicted,
  // evicted_tile_x, evicted_tile_y, evict_record, evict_new_record
  output logic [TLRC_OUT_W-1:0]     out_tdata
);

  tlrc_cmd_t    cmd;
  tlrc_status_t status;

  assign cfg_ready = 1'b1;

  tlrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tlrc_dp #(
    .GRID_TILES     (GRID_TILES),
    .RESIDENT_SLOTS (RESIDENT_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_tile_size (cfg_tile_size),
    .in_tdata      (in_tdata),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_tdata     (out_tdata),
    .cmd           (cmd),
    .status        (status)
  );

`include "tile_residency_lru_controller_top_assert.svh"

  `TLRC_ASSERT_IMP(a_miss_all_zero, out_tvalid && !out_tdata[0], out_tdata[46:1] == '0)
  `TLRC_ASSERT_IMP(a_evict_not_hit, out_tvalid && out_tdata[29], out_tdata[20:19] != LOAD_HIT)
  `TLRC_ASSERT_NEXT(a_busy_after_take, in_tvalid && in_tready, !in_tready)

endmodule

// ===== sim/tb_tile_residency_lru_controller_top.sv =====
// Testbench for tile_residency_lru_controller_top: random and directed point accesses
// with an inline LRU residency predictor, checked result by result on the output stream.
// Depends on tlrc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_tile_residency_lru_controller_top;
  import tlrc_pkg::*;

  localparam int NTILE = TLRC_GRID_TILES * TLRC_GRID_TILES;
  localparam int NSLOT = TLRC_RESIDENT_SLOTS;
  localparam int CYCLE_LIMIT = 900000;
  localparam int FLD_LSB [10] = '{0, 1, 3, 19, 21, 29, 30, 34, 38, 46};
  localparam int FLD_W   [10] = '{1, 2, 16, 2, 8, 1, 4, 4, 8, 1};

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [TLRC_TS_W-1:0] cfg_tile_size;
  logic in_tvalid, in_tready;
  logic [2*TLRC_COORD_W-1:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [TLRC_OUT_W-1:0] out_tdata;

  tile_residency_lru_controller_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_tile_size(cfg_tile_size),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // residency model
  logic [8:0] tile_size_q;
  bit         map_valid [NTILE];
  int         map_slot  [NTILE];
  int         backing   [NTILE];
  int         owner     [NSLOT];
  bit         used      [NSLOT];
  int         age       [NSLOT];
  int         next_rec, resident;

  logic [31:0] pending_reqs [$];
  logic [TLRC_OUT_W-1:0] expected_results [$];
  int snd_idle, rcv_idle, results_seen, mismatches, cycles;
  int hold_cnt;
  bit hold_done;

  function automatic void age_slots(int s, bit fresh);
    int old;
    old = age[s];
    for (int i = 0; i < NSLOT; i++)
      if (i != s && used[i] && (fresh || age[i] < old)) age[i]++;
    age[s] = 0;
  endfunction

  function automatic logic [TLRC_OUT_W-1:0] predict_access(logic [31:0] d);
    int ts, tx, ty, ox, oy, t, s, v, et;
    bit found;
    logic [1:0] la;
    logic [7:0] lr, er;
    logic ev, en;
    logic [3:0] ex, ey;
    ts = tile_size_q;
    la = LOAD_HIT; lr = 0; er = 0; ev = 0; en = 0; ex = 0; ey = 0;
    if (ts == 0) ts = 1;
    if (ts > 256) ts = 256;
    if (d[15] || d[31]) return '0;
    tx = d[15:0] / ts; ox = d[15:0] % ts;
    ty = d[31:16] / ts; oy = d[31:16] % ts;
    if (tx >= TLRC_GRID_TILES || ty >= TLRC_GRID_TILES) return '0;
    t = ty * TLRC_GRID_TILES + tx;
    if (map_valid[t]) begin
      s = map_slot[t];
      age_slots(s, 0);
    end else begin
      if (resident >= NSLOT) begin
        v = 0; found = 0;
        for (int i = 0; i < NSLOT; i++)
          if (used[i] && (!found || age[i] > age[v])) begin
            v = i; found = 1;
          end
        if (found) begin
          et = owner[v];
          ev = 1;
          ex = et % TLRC_GRID_TILES;
          ey = et / TLRC_GRID_TILES;
          if (backing[et] == 0) begin
            next_rec++;
            backing[et] = next_rec;
            en = 1;
          end
          er = backing[et] - 1;
          map_valid[et] = 0; used[v] = 0; age[v] = 0; resident--;
        end
      end
      s = 0;
      while (used[s]) s++;
      used[s] = 1; owner[s] = t; map_valid[t] = 1; map_slot[t] = s; resident++;
      age_slots(s, 1);
      if (backing[t] != 0) begin
        la = LOAD_READ; lr = backing[t] - 1;
      end else la = LOAD_ZERO;
    end
    return {1'b0, en, er, ey, ex, ev, lr, la, 16'(oy * ts + ox), 2'(s), 1'b1};
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[tile_residency_lru_controller_top] ERROR");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(predict_access(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= snd_idle) begin
          in_tdata <= pending_reqs.pop_front();
          in_tvalid <= 1;
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    logic [TLRC_OUT_W-1:0] exp_r;
    bit bad;
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          exp_r = expected_results.pop_front();
          bad = 0;
          for (int f = 0; f < 10; f++)
            if (((exp_r ^ out_tdata) >> FLD_LSB[f]) & ((48'd1 << FLD_W[f]) - 1)) bad = 1;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h actual %h", exp_r, out_tdata);
          end
        end
      end
      if (!hold_done && results_seen == 200) begin
        hold_done <= 1;
        hold_cnt <= 400;
        out_tready <= 0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_tready <= 0;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_tile_size(logic [8:0] v);
    cfg_valid <= 1;
    cfg_tile_size <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    tile_size_q = v;
  endtask

  function automatic logic [31:0] pack_pt(int x, int y);
    return {16'(y), 16'(x)};
  endfunction

  task automatic queue_random(int n, int ts_eff);
    int hot_x [6], hot_y [6], tx, ty, k;
    for (int i = 0; i < 6; i++) begin
      hot_x[i] = $urandom_range(15);
      hot_y[i] = $urandom_range(15);
    end
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 10) begin
        pending_reqs.push_back($urandom);
      end else begin
        if (k < 75) begin
          k = $urandom_range(5);
          tx = hot_x[k]; ty = hot_y[k];
        end else begin
          tx = $urandom_range(15); ty = $urandom_range(15);
        end
        pending_reqs.push_back(pack_pt(tx * ts_eff + $urandom_range(ts_eff - 1),
                                       ty * ts_eff + $urandom_range(ts_eff - 1)));
      end
    end
  endtask

  initial begin
    logic [8:0] sizes [6] = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd5, 9'd16};
    int eff;
    rst_n = 0;
    cfg_valid = 0; cfg_tile_size = '0;
    in_tvalid = 0; in_tdata = '0; out_tready = 0;
    cycles = 0; results_seen = 0; mismatches = 0; hold_cnt = 0; hold_done = 0;
    snd_idle = 33; rcv_idle = 53;
    tile_size_q = TLRC_TS_RESET;
    for (int i = 0; i < NTILE; i++) begin
      map_valid[i] = 0; map_slot[i] = 0; backing[i] = 0;
    end
    for (int i = 0; i < NSLOT; i++) begin
      used[i] = 0; age[i] = 0; owner[i] = 0;
    end
    next_rec = 0; resident = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    write_tile_size(9'd16);
    // directed: grid edges, outside points, eviction chain and reload
    pending_reqs.push_back(pack_pt(0, 0));
    pending_reqs.push_back(pack_pt(32767, 32767));
    pending_reqs.push_back(pack_pt(-1, 0));
    pending_reqs.push_back(pack_pt(0, -32768));
    pending_reqs.push_back(pack_pt(255, 255));
    pending_reqs.push_back(pack_pt(256, 0));
    pending_reqs.push_back(pack_pt(0, 256));
    pending_reqs.push_back(pack_pt(17, 0));
    pending_reqs.push_back(pack_pt(0, 33));
    pending_reqs.push_back(pack_pt(5, 3));
    pending_reqs.push_back(pack_pt(100, 200));
    pending_reqs.push_back(pack_pt(240, 15));
    pending_reqs.push_back(pack_pt(1, 1));
    pending_reqs.push_back(pack_pt(0, 0));
    pending_reqs.push_back(pack_pt(250, 250));
    pending_reqs.push_back(pack_pt(17, 1));
    pending_reqs.push_back(pack_pt(255, 255));
    pending_reqs.push_back(pack_pt(-32768, -32768));
    wait_drained();
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin snd_idle = 53; rcv_idle = 33; end
      if (p == 4) begin snd_idle = 0; rcv_idle = 0; end
      write_tile_size(sizes[p]);
      eff = (sizes[p] == 0) ? 1 : (sizes[p] > 256) ? 256 : sizes[p];
      queue_random(222, eff);
      wait_drained();
    end
    if (mismatches == 0) begin
      $display("[tile_residency_lru_controller_top] OK");
    end else begin
      $display("[tile_residency_lru_controller_top] ERROR");
    end
    $finish;
  end

endmodule
